/* src/crlba_pkg.sv */
// ----------------------------------------------------------------------------
// crlba_pkg
// Shared types and constants of the card result LED and buzzer annunciator.
// ----------------------------------------------------------------------------
package crlba_pkg;

	localparam int CntW     = 8;
	localparam int StatW    = 3;
	localparam int StepW    = 6;
	localparam int CfgIdxW  = 8;
	localparam int CfgDataW = 8;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] REG_OK_BEEP_TICKS       = 8'd0;
	localparam logic [CfgIdxW-1:0] REG_OK_LED_TICKS        = 8'd1;
	localparam logic [CfgIdxW-1:0] REG_BAD_BEEP_STEP_TICKS = 8'd2;
	localparam logic [CfgIdxW-1:0] REG_BAD_LED_TICKS       = 8'd3;

	// Reset values of the configuration registers.
	localparam logic [CntW-1:0]  OK_BEEP_TICKS_RST       = 8'd10;
	localparam logic [CntW-1:0]  OK_LED_TICKS_RST        = 8'd50;
	localparam logic [StepW-1:0] BAD_BEEP_STEP_TICKS_RST = 6'd10;
	localparam logic [CntW-1:0]  BAD_LED_TICKS_RST       = 8'd50;

	// Largest step that keeps five steps inside the counter.
	localparam logic [StepW-1:0] STEP_MAX = 6'd51;
	localparam logic [StepW-1:0] STEP_MIN = 6'd1;

	// Item kinds.
	localparam logic MODE_TICK   = 1'b0;
	localparam logic MODE_STATUS = 1'b1;

	// Poll status codes.
	localparam logic [StatW-1:0] ST_OK      = 3'd0;
	localparam logic [StatW-1:0] ST_RECEIVE = 3'd4;
	localparam logic [StatW-1:0] ST_WRONG   = 3'd5;

	typedef struct packed {
		logic [CntW-1:0]  ok_beep_ticks;
		logic [CntW-1:0]  ok_led_ticks;
		logic [StepW-1:0] bad_beep_step_ticks;
		logic [CntW-1:0]  bad_led_ticks;
	} cfg_t;

	typedef struct packed {
		logic ok_led;
		logic bad_led;
		logic buzzer_on;
	} drive_t;

	typedef struct packed {
		logic [StatW-1:0] last_status;
		logic             ok_beep_active;
		logic             ok_led_active;
		logic             bad_beep_active;
		logic             bad_led_active;
		logic [CntW-1:0]  ok_beep_count;
		logic [CntW-1:0]  ok_led_count;
		logic [CntW-1:0]  bad_beep_count;
		logic [CntW-1:0]  bad_led_count;
		drive_t           drive;
	} state_t;

endpackage

/* src/crlba_if.sv */
// ----------------------------------------------------------------------------
// crlba channel interfaces
// Valid/ready channels for items, results and configuration writes.
// ----------------------------------------------------------------------------
interface crlba_item_if;
	logic                         valid;
	logic                         ready;
	logic                         mode;
	logic [crlba_pkg::StatW-1:0]  status;

	modport source (output valid, mode, status, input ready);
	modport sink (input valid, mode, status, output ready);
endinterface

interface crlba_result_if;
	logic valid;
	logic ready;
	logic ok_led;
	logic bad_led;
	logic buzzer_on;

	modport source (output valid, ok_led, bad_led, buzzer_on, input ready);
	modport sink (input valid, ok_led, bad_led, buzzer_on, output ready);
endinterface

interface crlba_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [crlba_pkg::CfgIdxW-1:0]  index;
	logic [crlba_pkg::CfgDataW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* src/crlba_update.sv */
// ----------------------------------------------------------------------------
// crlba_update
// Next-state logic for one tick or one status report.
// ----------------------------------------------------------------------------
module crlba_update (
	input  crlba_pkg::cfg_t                 cfg,
	input  crlba_pkg::state_t               cur,
	input  logic                            mode,
	input  logic [crlba_pkg::StatW-1:0]     status,
	output crlba_pkg::state_t               nxt
);

	logic [crlba_pkg::StepW-1:0] step;
	logic [crlba_pkg::CntW-1:0]  step1;
	logic [crlba_pkg::CntW-1:0]  step2;
	logic [crlba_pkg::CntW-1:0]  step3;
	logic [crlba_pkg::CntW-1:0]  step4;
	logic [crlba_pkg::CntW-1:0]  step5;
	logic                        prev_rx_or_wrong;
	logic                        prev_rx_or_ok;

	// Clamp the step so that five steps stay within the 8-bit counter.
	always_comb begin
		if (cfg.bad_beep_step_ticks == '0) begin
			step = crlba_pkg::STEP_MIN;
		end else if (cfg.bad_beep_step_ticks > crlba_pkg::STEP_MAX) begin
			step = crlba_pkg::STEP_MAX;
		end else begin
			step = cfg.bad_beep_step_ticks;
		end
	end

	assign step1 = {2'b00, step};
	assign step2 = {1'b0, step, 1'b0};
	assign step3 = step1 + step2;
	assign step4 = {step, 2'b00};
	assign step5 = step4 + step1;

	assign prev_rx_or_wrong = (cur.last_status == crlba_pkg::ST_RECEIVE) ||
	                          (cur.last_status == crlba_pkg::ST_WRONG);
	assign prev_rx_or_ok    = (cur.last_status == crlba_pkg::ST_RECEIVE) ||
	                          (cur.last_status == crlba_pkg::ST_OK);

	always_comb begin
		nxt = cur;
		if (mode == crlba_pkg::MODE_TICK) begin
			if (cur.ok_beep_active) begin
				nxt.ok_beep_count = cur.ok_beep_count + 8'd1;
				if (nxt.ok_beep_count == cfg.ok_beep_ticks) begin
					nxt.ok_beep_count   = '0;
					nxt.ok_beep_active  = 1'b0;
					nxt.drive.buzzer_on = 1'b0;
				end
			end
			if (cur.ok_led_active) begin
				nxt.ok_led_count = cur.ok_led_count + 8'd1;
				if (nxt.ok_led_count == cfg.ok_led_ticks) begin
					nxt.ok_led_count  = '0;
					nxt.ok_led_active = 1'b0;
					nxt.drive.ok_led  = 1'b0;
				end
			end
			if (cur.bad_beep_active) begin
				nxt.bad_beep_count = cur.bad_beep_count + 8'd1;
				// Most counts hit no step boundary and leave the buzzer as it is.
				if (nxt.bad_beep_count == step1) begin
					nxt.drive.buzzer_on = 1'b0;
				end else if (nxt.bad_beep_count == step2) begin
					nxt.drive.buzzer_on = 1'b1;
				end else if (nxt.bad_beep_count == step3) begin
					nxt.drive.buzzer_on = 1'b0;
				end else if (nxt.bad_beep_count == step4) begin
					nxt.drive.buzzer_on = 1'b1;
				end else if (nxt.bad_beep_count == step5) begin
					nxt.bad_beep_active = 1'b0;
					nxt.drive.buzzer_on = 1'b0;
				end
			end
			if (cur.bad_led_active) begin
				nxt.bad_led_count = cur.bad_led_count + 8'd1;
				if (nxt.bad_led_count == cfg.bad_led_ticks) begin
					nxt.bad_led_count  = '0;
					nxt.bad_led_active = 1'b0;
					nxt.drive.bad_led  = 1'b0;
				end
			end
		end else begin
			if (status == crlba_pkg::ST_OK && prev_rx_or_wrong) begin
				nxt.bad_led_active  = 1'b0;
				nxt.bad_beep_active = 1'b0;
				nxt.ok_led_active   = 1'b1;
				nxt.ok_beep_active  = 1'b1;
				nxt.drive           = '{ok_led: 1'b1, bad_led: 1'b0, buzzer_on: 1'b1};
				nxt.ok_beep_count   = '0;
				nxt.ok_led_count    = '0;
				nxt.bad_beep_count  = '0;
				nxt.bad_led_count   = '0;
			end else if (status == crlba_pkg::ST_WRONG && prev_rx_or_ok) begin
				nxt.ok_led_active   = 1'b0;
				nxt.ok_beep_active  = 1'b0;
				nxt.bad_led_active  = 1'b1;
				nxt.bad_beep_active = 1'b1;
				nxt.drive           = '{ok_led: 1'b0, bad_led: 1'b1, buzzer_on: 1'b1};
				nxt.ok_beep_count   = '0;
				nxt.ok_led_count    = '0;
				nxt.bad_beep_count  = '0;
				nxt.bad_led_count   = '0;
			end
			nxt.last_status = status;
		end
	end

endmodule

/* src/card_result_led_buzzer_annunciator_core.sv */
// ----------------------------------------------------------------------------
// card_result_led_buzzer_annunciator_core
// Drives the OK LED, the wrong-card LED and the buzzer from ticks and status.
// ----------------------------------------------------------------------------
// Result: registered, and shown in the cycle after its item is accepted.
// Throughput: one item per cycle; the drive register doubles as the result
// register, so a new item is taken whenever the result slot is empty or drains.
// Reset: all indications off, counters zero, configuration at its defaults.
// Configuration writes are taken in every cycle.
module card_result_led_buzzer_annunciator_core (
	input  logic                   clk,
	input  logic                   arst_n,
	crlba_item_if.sink             item,
	crlba_result_if.source         result,
	crlba_cfg_if.sink              cfg
);

	crlba_pkg::cfg_t   cfg_q;
	crlba_pkg::state_t state_q;
	crlba_pkg::state_t state_nxt;
	logic              out_valid_q;
	logic              item_fire;

	assign cfg.ready  = 1'b1;
	assign item.ready = !out_valid_q || result.ready;
	assign item_fire  = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ok_beep_ticks       <= crlba_pkg::OK_BEEP_TICKS_RST;
			cfg_q.ok_led_ticks        <= crlba_pkg::OK_LED_TICKS_RST;
			cfg_q.bad_beep_step_ticks <= crlba_pkg::BAD_BEEP_STEP_TICKS_RST;
			cfg_q.bad_led_ticks       <= crlba_pkg::BAD_LED_TICKS_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				crlba_pkg::REG_OK_BEEP_TICKS: cfg_q.ok_beep_ticks <= cfg.data;
				crlba_pkg::REG_OK_LED_TICKS: cfg_q.ok_led_ticks <= cfg.data;
				crlba_pkg::REG_BAD_BEEP_STEP_TICKS:
					cfg_q.bad_beep_step_ticks <= cfg.data[crlba_pkg::StepW-1:0];
				crlba_pkg::REG_BAD_LED_TICKS: cfg_q.bad_led_ticks <= cfg.data;
				default: ;
			endcase
		end
	end

	crlba_update u_update (
		.cfg    (cfg_q),
		.cur    (state_q),
		.mode   (item.mode),
		.status (item.status),
		.nxt    (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (item_fire) begin
				state_q <= state_nxt;
			end
			if (item_fire) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid     = out_valid_q;
	assign result.ok_led    = state_q.drive.ok_led;
	assign result.bad_led   = state_q.drive.bad_led;
	assign result.buzzer_on = state_q.drive.buzzer_on;

endmodule

/* src/crlba_checker.sv */
// ----------------------------------------------------------------------------
// crlba_checker
// Port-level checks of the annunciator, bound to the annunciator core.
// ----------------------------------------------------------------------------
module crlba_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic ok_led,
	input logic bad_led,
	input logic buzzer_on
);

	// A stalled result keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({ok_led, bad_led, buzzer_on}))
		else $error("stalled result changed");

	// Every accepted transaction shows a result in the next cycle.
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted item produced no result");

	// A waiting result blocks new items so it cannot be overwritten.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("item accepted over a stalled result");

	// The two indications exclude each other.
	a_led_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(ok_led && bad_led))
		else $error("both LEDs lit");

endmodule

bind card_result_led_buzzer_annunciator_core crlba_checker u_crlba_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.ok_led    (result.ok_led),
	.bad_led   (result.bad_led),
	.buzzer_on (result.buzzer_on)
);
